### hw/rtl/u8sv_pkg.sv
// ----------------------------------------------------------------------------
// u8sv_pkg
// Types, constants and helpers shared by the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8sv_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_LEN_W  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_NAME_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 1'b1;

    localparam logic [CFG_LEN_W-1:0] MAX_LEN_RESET = 11'd256;

    // Byte and code point constants
    localparam logic [7:0]  BYTE_NUL   = 8'h00;
    localparam logic [7:0]  BYTE_DOT   = 8'h2E;
    localparam int          CP_W       = 21;
    localparam logic [20:0] CP_MIN_3B  = 21'h000800;
    localparam logic [20:0] CP_MIN_4B  = 21'h010000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;

    // Sequence lengths, counted as continuation bytes
    localparam logic [1:0] SEQ_2B = 2'd1;
    localparam logic [1:0] SEQ_3B = 2'd2;
    localparam logic [1:0] SEQ_4B = 2'd3;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_EMPTY     = 4'd1,
        ERR_NUL       = 4'd2,
        ERR_LEAD      = 4'd3,
        ERR_CONT      = 4'd4,
        ERR_TRUNC     = 4'd5,
        ERR_OVERLONG  = 4'd6,
        ERR_SURROGATE = 4'd7,
        ERR_LARGE     = 4'd8,
        ERR_DOT       = 4'd9,
        ERR_LONG      = 4'd10
    } err_t;

    // Decoder state carried from beat to beat (byte count kept apart)
    typedef struct packed {
        logic [1:0]      pend;
        logic [1:0]      seqlen;
        logic [CP_W-1:0] acc;
        err_t            err;
    } dec_t;

    typedef struct packed {
        logic valid_res;
        err_t error_code;
    } verdict_t;

    localparam dec_t DEC_CLEAR = '{pend: 2'd0, seqlen: 2'd0, acc: '0, err: ERR_NONE};

    // Record an error: decoding stops, open sequence dropped
    function automatic dec_t dec_fail(input err_t code);
        dec_t d;
        d     = DEC_CLEAR;
        d.err = code;
        return d;
    endfunction

endpackage

### hw/rtl/u8sv_if.sv
// ----------------------------------------------------------------------------
// u8sv_if
// Valid/ready channels: byte beats in, verdict beats out.
// ----------------------------------------------------------------------------
interface u8sv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

interface u8sv_verdict_if #(parameter int CNT_W = 11);
    logic             valid;
    logic             ready;
    logic             valid_res;
    logic [3:0]       error_code;
    logic [CNT_W-1:0] byte_count;

    modport source (output valid, output valid_res, output error_code,
                    output byte_count, input ready);
    modport sink   (input valid, input valid_res, input error_code,
                    input byte_count, output ready);
endinterface

### hw/rtl/u8sv_step.sv
// ----------------------------------------------------------------------------
// u8sv_step
// Per-beat decode: next decoder state, byte count and verdict.
// ----------------------------------------------------------------------------
module u8sv_step #(
    parameter int COUNT_LIMIT = 1024,
    parameter int CNT_W       = 11
) (
    input  logic [7:0]                   data_byte,
    input  logic                         has_byte,
    input  logic                         last,
    input  logic                         name_mode,
    input  logic [u8sv_pkg::CFG_LEN_W-1:0] max_name_length,
    input  u8sv_pkg::dec_t               cur,
    input  logic [CNT_W-1:0]             cur_count,
    output u8sv_pkg::dec_t               nxt,
    output logic [CNT_W-1:0]             nxt_count,
    output u8sv_pkg::verdict_t           res,
    output logic [CNT_W-1:0]             res_count
);

    localparam int CMP_W = (CNT_W > u8sv_pkg::CFG_LEN_W) ? CNT_W : u8sv_pkg::CFG_LEN_W;
    localparam logic [CNT_W-1:0] SAT_COUNT = CNT_W'(COUNT_LIMIT + 1);

    u8sv_pkg::dec_t            dec;
    logic [CNT_W-1:0]          cnt;
    logic [u8sv_pkg::CP_W-1:0] acc_sh;
    u8sv_pkg::err_t            verdict_err;

    assign acc_sh = {cur.acc[u8sv_pkg::CP_W-7:0], data_byte[5:0]};

    always_comb
    begin
        dec = cur;
        cnt = cur_count;
        if (has_byte)
        begin
            if (cnt < SAT_COUNT)
            begin
                cnt = cnt + 1'b1;
            end
            if (cur.err == u8sv_pkg::ERR_NONE)
            begin
                if (name_mode && (CMP_W'(cnt) > CMP_W'(max_name_length)))
                begin
                    dec = u8sv_pkg::dec_fail(u8sv_pkg::ERR_LONG);
                end
                else if (name_mode && (data_byte == u8sv_pkg::BYTE_DOT))
                begin
                    dec = u8sv_pkg::dec_fail(u8sv_pkg::ERR_DOT);
                end
                else if (cur.pend != 2'd0)
                begin
                    // continuation byte expected
                    if (data_byte[7:6] != 2'b10)
                    begin
                        dec = u8sv_pkg::dec_fail(u8sv_pkg::ERR_CONT);
                    end
                    else
                    begin
                        dec.acc  = acc_sh;
                        dec.pend = cur.pend - 2'd1;
                        if (cur.pend == 2'd1)
                        begin
                            if (((cur.seqlen == u8sv_pkg::SEQ_3B) &&
                                 (acc_sh < u8sv_pkg::CP_MIN_3B)) ||
                                ((cur.seqlen == u8sv_pkg::SEQ_4B) &&
                                 (acc_sh < u8sv_pkg::CP_MIN_4B)))
                            begin
                                dec = u8sv_pkg::dec_fail(u8sv_pkg::ERR_OVERLONG);
                            end
                            else if (acc_sh > u8sv_pkg::CP_MAX)
                            begin
                                dec = u8sv_pkg::dec_fail(u8sv_pkg::ERR_LARGE);
                            end
                            else if ((acc_sh >= u8sv_pkg::CP_SURR_LO) &&
                                     (acc_sh <= u8sv_pkg::CP_SURR_HI))
                            begin
                                dec = u8sv_pkg::dec_fail(u8sv_pkg::ERR_SURROGATE);
                            end
                            else
                            begin
                                dec.seqlen = 2'd0;
                                dec.acc    = '0;
                            end
                        end
                    end
                end
                else if (data_byte == u8sv_pkg::BYTE_NUL)
                begin
                    dec = u8sv_pkg::dec_fail(u8sv_pkg::ERR_NUL);
                end
                else if (data_byte[7] == 1'b0)
                begin
                    dec = cur;
                end
                else if (data_byte[7:5] == 3'b110)
                begin
                    // C0/C1 can only encode ASCII
                    if (data_byte[4:1] == 4'd0)
                    begin
                        dec = u8sv_pkg::dec_fail(u8sv_pkg::ERR_OVERLONG);
                    end
                    else
                    begin
                        dec.acc    = u8sv_pkg::CP_W'(data_byte[4:0]);
                        dec.pend   = 2'd1;
                        dec.seqlen = u8sv_pkg::SEQ_2B;
                    end
                end
                else if (data_byte[7:4] == 4'b1110)
                begin
                    dec.acc    = u8sv_pkg::CP_W'(data_byte[3:0]);
                    dec.pend   = 2'd2;
                    dec.seqlen = u8sv_pkg::SEQ_3B;
                end
                else if (data_byte[7:3] == 5'b11110)
                begin
                    dec.acc    = u8sv_pkg::CP_W'(data_byte[2:0]);
                    dec.pend   = 2'd3;
                    dec.seqlen = u8sv_pkg::SEQ_4B;
                end
                else
                begin
                    dec = u8sv_pkg::dec_fail(u8sv_pkg::ERR_LEAD);
                end
            end
        end

        verdict_err = dec.err;
        if ((verdict_err == u8sv_pkg::ERR_NONE) && (dec.pend != 2'd0))
        begin
            verdict_err = u8sv_pkg::ERR_TRUNC;
        end
        if ((verdict_err == u8sv_pkg::ERR_NONE) && (cnt == '0))
        begin
            verdict_err = u8sv_pkg::ERR_EMPTY;
        end
        res.valid_res  = (verdict_err == u8sv_pkg::ERR_NONE);
        res.error_code = verdict_err;
        res_count      = cnt;

        if (last)
        begin
            nxt       = u8sv_pkg::DEC_CLEAR;
            nxt_count = '0;
        end
        else
        begin
            nxt       = dec;
            nxt_count = cnt;
        end
    end

endmodule

### hw/rtl/u8sv_out_stage.sv
// ----------------------------------------------------------------------------
// u8sv_out_stage
// Verdict register; holds a beat until the sink takes it.
// ----------------------------------------------------------------------------
module u8sv_out_stage #(
    parameter int CNT_W = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  u8sv_pkg::verdict_t   res,
    input  logic [CNT_W-1:0]     res_count,
    output logic                 take_ready,
    u8sv_verdict_if.source       verdict
);

    logic               valid_reg;
    logic               valid_next;
    u8sv_pkg::verdict_t res_reg;
    logic [CNT_W-1:0]   count_reg;

    // a new beat may enter while the held one leaves
    assign take_ready = !valid_reg || verdict.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (verdict.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg   <= res;
            count_reg <= res_count;
        end
    end

    assign verdict.valid      = valid_reg;
    assign verdict.valid_res  = res_reg.valid_res;
    assign verdict.error_code = res_reg.error_code;
    assign verdict.byte_count = count_reg;

endmodule

### hw/rtl/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator: strict UTF-8 check of a byte stream, one byte a beat.
// Throughput one beat per cycle unless stalled; the verdict appears in the cycle after the last beat.
// Input stalls only while a verdict is held and the verdict side is not ready.
// Reset: stream state cleared, name_mode 0, max_name_length 256, no verdict held.
// ----------------------------------------------------------------------------
module utf8_stream_validator #(
    parameter int COUNT_LIMIT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [u8sv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [u8sv_pkg::CFG_DATA_W-1:0] cfg_data,
    u8sv_byte_if.sink                       text,
    u8sv_verdict_if.source                  verdict
);

    // count width: enough for COUNT_LIMIT + 1
    localparam int CNT_W = $clog2(COUNT_LIMIT + 2);

    // Configuration registers. The user must write them only while idle, so each
    // byte sees the values current when it is accepted. The block does not enforce it.
    logic                           name_mode_reg;
    logic [u8sv_pkg::CFG_LEN_W-1:0] max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_mode_reg <= 1'b0;
            max_len_reg   <= u8sv_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == u8sv_pkg::CFG_NAME_MODE)
            begin
                name_mode_reg <= cfg_data[0];
            end
            if (cfg_index == u8sv_pkg::CFG_MAX_LEN)
            begin
                max_len_reg <= cfg_data[u8sv_pkg::CFG_LEN_W-1:0];
            end
        end
    end

    // Stream state: open sequence, partial code point, first error, count
    u8sv_pkg::dec_t     dec_reg;
    u8sv_pkg::dec_t     dec_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    u8sv_pkg::verdict_t res;
    logic [CNT_W-1:0]   res_count;
    logic               take_ready;
    logic               accept;

    assign text.ready = take_ready;
    assign accept     = text.valid && take_ready;

    // Whole decode of one byte is a single pass of narrow logic
    u8sv_step #(
        .COUNT_LIMIT (COUNT_LIMIT),
        .CNT_W       (CNT_W)
    ) u_step (
        .data_byte       (text.data_byte),
        .has_byte        (text.has_byte),
        .last            (text.last),
        .name_mode       (name_mode_reg),
        .max_name_length (max_len_reg),
        .cur             (dec_reg),
        .cur_count       (count_reg),
        .nxt             (dec_next),
        .nxt_count       (count_next),
        .res             (res),
        .res_count       (res_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg   <= u8sv_pkg::DEC_CLEAR;
            count_reg <= '0;
        end
        else if (accept)
        begin
            dec_reg   <= dec_next;
            count_reg <= count_next;
        end
    end

    // Verdict beat registered on the last byte; input keeps flowing while
    // the sink drains it.
    u8sv_out_stage #(
        .CNT_W (CNT_W)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && text.last),
        .res        (res),
        .res_count  (res_count),
        .take_ready (take_ready),
        .verdict    (verdict)
    );

endmodule
